>>> sv/bbc_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and constants of the block reference bitmap checker
package bbc_pkg;

    // default store depth in blocks
    localparam int MAX_BLOCKS_DEF = 1024;

    // configuration register widths and indexes
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_FS_SIZE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_BLOCKS = 1'd1;
    localparam logic [CFG_W-1:0]     FS_SIZE_RST     = 11'd1024;
    localparam logic [CFG_W-1:0]     DATA_BLOCKS_RST = 11'd0;

    // operation codes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_CHECK = 2'd1;
    localparam logic [1:0] OP_SWEEP = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK              = 3'd0;
    localparam logic [2:0] ST_BAD_DIRECT      = 3'd1;
    localparam logic [2:0] ST_BAD_INDIRECT    = 3'd2;
    localparam logic [2:0] ST_MARKED_FREE     = 3'd3;
    localparam logic [2:0] ST_DIRECT_REUSED   = 3'd4;
    localparam logic [2:0] ST_INDIRECT_REUSED = 3'd5;
    localparam logic [2:0] ST_ALLOC_UNUSED    = 3'd6;

    // input item
    typedef struct packed {
        logic [1:0]  op;
        logic [6:0]  bitmap_byte_index;
        logic [7:0]  bitmap_byte;
        logic [31:0] block_addr;
        logic        ref_kind;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [2:0] status;
        logic [9:0] offending_block;
    } t_out_item;

    // store access controls from the sequencer
    typedef struct packed {
        logic rd_en;
        logic al_we;
        logic us_we;
    } t_mem_ctl;

endpackage

>>> sv/bbc_store.sv
`timescale 1ns / 1ps
// allocation bitmap and used map, eight blocks per row, registered read
module bbc_store #(
    parameter int ROWS = 128,
    parameter int RW   = 7
) (
    input  logic              i_clk,
    input  bbc_pkg::t_mem_ctl i_ctl,
    input  logic [RW-1:0]     i_row,
    input  logic [7:0]        i_al_wdata,
    input  logic [7:0]        i_us_wdata,
    output logic [7:0]        o_al_q,
    output logic [7:0]        o_us_q
);

    logic [7:0] r_alloc [ROWS];
    logic [7:0] r_used  [ROWS];
    logic [7:0] r_al_q;
    logic [7:0] r_us_q;

    // one shared row address, writes and registered reads
    always_ff @(posedge i_clk) begin
        if (i_ctl.al_we) begin
            r_alloc[i_row] <= i_al_wdata;
        end
        if (i_ctl.us_we) begin
            r_used[i_row] <= i_us_wdata;
        end
        if (i_ctl.rd_en) begin
            r_al_q <= r_alloc[i_row];
            r_us_q <= r_used[i_row];
        end
    end

    assign o_al_q = r_al_q;
    assign o_us_q = r_us_q;

endmodule

>>> sv/bbc_ctrl.sv
`timescale 1ns / 1ps
// sequencer: clearing pass, bitmap load, reference check and sweep
module bbc_ctrl #(
    parameter int MAX_BLOCKS = bbc_pkg::MAX_BLOCKS_DEF,
    parameter int ROWS       = (MAX_BLOCKS + 7) / 8,
    parameter int RW         = $clog2(ROWS)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  bbc_pkg::t_in_item         i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output bbc_pkg::t_out_item        o_out_data,
    input  logic [bbc_pkg::CFG_W-1:0] i_fs_size,
    input  logic [bbc_pkg::CFG_W-1:0] i_data_blocks,
    output bbc_pkg::t_mem_ctl         o_mem_ctl,
    output logic [RW-1:0]             o_mem_row,
    output logic [7:0]                o_al_wdata,
    output logic [7:0]                o_us_wdata,
    input  logic [7:0]                i_al_q,
    input  logic [7:0]                i_us_q
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SWEEP,
        S_DONE
    } t_state;

    t_state                    r_state, n_state;
    logic [RW-1:0]             r_clr_row, n_clr_row;
    logic [31:0]               r_addr, n_addr;
    logic                      r_kind, n_kind;
    logic [bbc_pkg::CFG_W-1:0] r_blk, n_blk;
    logic [bbc_pkg::CFG_W-1:0] r_pblk, n_pblk;
    logic                      r_pv, n_pv;
    logic [2:0]                r_status, n_status;
    logic [9:0]                r_offender, n_offender;
    logic                      r_out_valid, n_out_valid;
    bbc_pkg::t_out_item        r_out, n_out;

    logic [bbc_pkg::CFG_W-1:0] eff;
    logic [bbc_pkg::CFG_W-1:0] nd;
    logic [bbc_pkg::CFG_W-1:0] lo;
    logic                      accept;
    logic                      out_free;

    // effective data range from the configuration
    always_comb begin
        eff = (32'(i_fs_size) > 32'(MAX_BLOCKS)) ? bbc_pkg::CFG_W'(MAX_BLOCKS) : i_fs_size;
        nd  = (i_data_blocks > eff) ? eff : i_data_blocks;
        lo  = eff - nd;
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // next state and store access
    always_comb begin
        n_state     = r_state;
        n_clr_row   = r_clr_row;
        n_addr      = r_addr;
        n_kind      = r_kind;
        n_blk       = r_blk;
        n_pblk      = r_pblk;
        n_pv        = r_pv;
        n_status    = r_status;
        n_offender  = r_offender;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_mem_ctl   = '0;
        o_mem_row   = '0;
        o_al_wdata  = '0;
        o_us_wdata  = '0;

        // result taken downstream
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                o_mem_ctl.al_we = 1'b1;
                o_mem_ctl.us_we = 1'b1;
                o_mem_row       = r_clr_row;
                if (r_clr_row == RW'(ROWS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_row = r_clr_row + RW'(1);
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_status   = bbc_pkg::ST_OK;
                    n_offender = '0;
                    case (i_in_data.op)
                        bbc_pkg::OP_LOAD: begin
                            // bytes past the store are dropped
                            if (32'(i_in_data.bitmap_byte_index) < 32'(ROWS)) begin
                                o_mem_ctl.al_we = 1'b1;
                                o_mem_row       = RW'(i_in_data.bitmap_byte_index);
                                o_al_wdata      = i_in_data.bitmap_byte;
                            end
                            n_state = S_DONE;
                        end
                        bbc_pkg::OP_CHECK: begin
                            o_mem_ctl.rd_en = 1'b1;
                            o_mem_row       = RW'(i_in_data.block_addr >> 3);
                            n_addr          = i_in_data.block_addr;
                            n_kind          = i_in_data.ref_kind;
                            n_state         = S_CHECK;
                        end
                        bbc_pkg::OP_SWEEP: begin
                            n_blk   = lo;
                            n_pv    = 1'b0;
                            n_state = S_SWEEP;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_CHECK: begin
                // range, allocation and reuse checks on the fetched row
                o_mem_row = RW'(r_addr >> 3);
                if (r_addr != 32'd0) begin
                    if (r_addr < 32'(lo) || r_addr >= 32'(eff)) begin
                        n_status = r_kind ? bbc_pkg::ST_BAD_INDIRECT
                                          : bbc_pkg::ST_BAD_DIRECT;
                    end else if (!i_al_q[r_addr[2:0]]) begin
                        n_status = bbc_pkg::ST_MARKED_FREE;
                    end else if (i_us_q[r_addr[2:0]]) begin
                        n_status = r_kind ? bbc_pkg::ST_INDIRECT_REUSED
                                          : bbc_pkg::ST_DIRECT_REUSED;
                    end else begin
                        o_mem_ctl.us_we = 1'b1;
                        o_us_wdata      = i_us_q | (8'h01 << r_addr[2:0]);
                    end
                end
                n_state = S_DONE;
            end
            S_SWEEP: begin
                // fetch one block per cycle, test the previous fetch
                if (r_blk < eff) begin
                    o_mem_ctl.rd_en = 1'b1;
                    o_mem_row       = RW'(r_blk >> 3);
                    n_blk           = r_blk + bbc_pkg::CFG_W'(1);
                    n_pblk          = r_blk;
                    n_pv            = 1'b1;
                end else begin
                    n_pv = 1'b0;
                end
                if (r_pv && i_al_q[r_pblk[2:0]] && !i_us_q[r_pblk[2:0]]) begin
                    n_status   = bbc_pkg::ST_ALLOC_UNUSED;
                    n_offender = 10'(r_pblk);
                    n_state    = S_DONE;
                end else if (!r_pv && r_blk >= eff) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid           = 1'b1;
                    n_out.status          = r_status;
                    n_out.offending_block = r_offender;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_row   <= '0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_row   <= n_clr_row;
            r_pv        <= n_pv;
            r_out_valid <= n_out_valid;
        end
        r_addr     <= n_addr;
        r_kind     <= n_kind;
        r_blk      <= n_blk;
        r_pblk     <= n_pblk;
        r_status   <= n_status;
        r_offender <= n_offender;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> sv/block_reference_bitmap_checker_core.sv
`timescale 1ns / 1ps
// load: writes the bitmap byte, result registered; reference check: row fetch, then test
// sweep: walks the data range, stops at the first allocated but unused block
// throughput: one item at a time; the next input is taken once the result is registered
// reset: synchronous; config to fs_size 1024, data_blocks 0, then a clearing pass
// zeroes both maps, input not ready until it is done
// top level of the block reference bitmap checker
module block_reference_bitmap_checker_core #(
    parameter int MAX_BLOCKS = bbc_pkg::MAX_BLOCKS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  bbc_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output bbc_pkg::t_out_item            o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bbc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bbc_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int ROWS = (MAX_BLOCKS + 7) / 8;
    localparam int RW   = $clog2(ROWS);

    logic [bbc_pkg::CFG_W-1:0] r_fs_size;
    logic [bbc_pkg::CFG_W-1:0] r_data_blocks;
    bbc_pkg::t_mem_ctl         mem_ctl;
    logic [RW-1:0]             mem_row;
    logic [7:0]                al_wdata;
    logic [7:0]                us_wdata;
    logic [7:0]                al_q;
    logic [7:0]                us_q;

    // configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs_size     <= bbc_pkg::FS_SIZE_RST;
            r_data_blocks <= bbc_pkg::DATA_BLOCKS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bbc_pkg::REG_FS_SIZE:     r_fs_size     <= i_cfg_data;
                bbc_pkg::REG_DATA_BLOCKS: r_data_blocks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // sequencer
    bbc_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .ROWS       (ROWS),
        .RW         (RW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_data    (o_out_data),
        .i_fs_size     (r_fs_size),
        .i_data_blocks (r_data_blocks),
        .o_mem_ctl     (mem_ctl),
        .o_mem_row     (mem_row),
        .o_al_wdata    (al_wdata),
        .o_us_wdata    (us_wdata),
        .i_al_q        (al_q),
        .i_us_q        (us_q)
    );

    // bitmap and used map
    bbc_store #(
        .ROWS (ROWS),
        .RW   (RW)
    ) u_store (
        .i_clk      (i_clk),
        .i_ctl      (mem_ctl),
        .i_row      (mem_row),
        .i_al_wdata (al_wdata),
        .i_us_wdata (us_wdata),
        .o_al_q     (al_q),
        .o_us_q     (us_q)
    );

endmodule

>>> sv/bbc_checker.sv
`timescale 1ns / 1ps
// port-level checks of the block reference bitmap checker, bound to the top level
module bbc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input bbc_pkg::t_out_item o_out_data
);

    // clearing pass keeps input closed right after reset
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("input ready right after reset");

    // one item at a time
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready in the cycle after a transfer");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result dropped or changed");

    // offending block only with the sweep status
    a_offender_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != bbc_pkg::ST_ALLOC_UNUSED)
            |-> (o_out_data.offending_block == 10'd0))
        else $error("nonzero offending block without sweep status");

    // status within the defined codes
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status <= bbc_pkg::ST_ALLOC_UNUSED))
        else $error("undefined status code");

endmodule

bind block_reference_bitmap_checker_core bbc_checker u_bbc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
